// ===== rtl/rfid_uid_report_dedup_unit_assert.svh =====
// assertion macros for the uid report dedup unit
// expects a clock i_clk and an active-low reset i_rst_n in the including scope
`ifndef RFID_UID_REPORT_DEDUP_UNIT_ASSERT_SVH
`define RFID_UID_REPORT_DEDUP_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RUDD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must never be seen outside reset
`define RUDD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/rudd_pkg.sv =====
// shared types, character constants and helpers for the uid report dedup unit
// no dependencies
`default_nettype none

package rudd_pkg;

    localparam int SIZE_W     = 4;
    localparam int CHAR_W     = 8;
    localparam int IN_TDATA_W = 88;
    localparam int IN_TUSER_W = 1;

    localparam logic [CHAR_W-1:0] CH_I     = 8'h49;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [3:0]        NIB_TEN  = 4'd10;

    // presence machine
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_REP1,
        PH_REP2
    } t_phase;

    // report line serialiser
    typedef enum logic [2:0] {
        S_I,
        S_SZ_HI,
        S_SZ_LO,
        S_SPACE,
        S_HI,
        S_LO,
        S_CR,
        S_LF
    } t_ser;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    // lowercase hex digit of one nibble
    function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] v);
        logic [CHAR_W-1:0] res;
        if (v < NIB_TEN) begin
            res = CH_ZERO + CHAR_W'(v);
        end else begin
            res = CH_A + CHAR_W'(v - NIB_TEN);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rudd_queue.sv =====
// two-entry report queue between the classifier and the serialiser
// depends on rudd_pkg
`default_nettype none

module rudd_queue
    import rudd_pkg::*;
#(
    parameter int WIDTH = 84
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_head,
    output t_q_flags              o_flags
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;

    assign o_head        = r_mem[r_rd];
    assign o_flags.full  = (r_count == 2'(DEPTH));
    assign o_flags.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rudd_front.sv =====
// front end: presence machine, uid comparison and report decision
// depends on rudd_pkg; feeds rudd_queue
`default_nettype none

module rudd_front
    import rudd_pkg::*;
#(
    parameter int UID_BYTES = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic                   i_kind,
    input  wire logic                   i_card_present,
    input  wire logic                   i_read_ok,
    input  wire logic [SIZE_W-1:0]      i_uid_size,
    input  wire logic [UID_BYTES*8-1:0] i_uid_bytes,
    input  wire t_q_flags               i_q_flags,
    output logic                        o_push,
    output logic [SIZE_W-1:0]           o_push_size,
    output logic [UID_BYTES*8-1:0]      o_push_bytes
);

    t_phase                 r_phase, n_phase;
    logic [SIZE_W-1:0]      r_rem_size;
    logic [UID_BYTES*8-1:0] r_rem_uid;

    logic              accept;
    logic              present;
    logic              differs;
    logic              report;
    logic [SIZE_W-1:0] size_cl;
    logic              byte_diff;

    assign o_ready = !i_q_flags.full;
    assign accept  = i_valid && o_ready;
    assign present = i_card_present && i_read_ok;
    assign size_cl = (i_uid_size > SIZE_W'(UID_BYTES)) ? SIZE_W'(UID_BYTES) : i_uid_size;

    // any valid byte that differs from the remembered one
    always_comb begin
        byte_diff = 1'b0;
        for (int i = 0; i < UID_BYTES; i++) begin
            if ((SIZE_W'(i) < size_cl) && (r_rem_uid[i*8 +: 8] != i_uid_bytes[i*8 +: 8])) begin
                byte_diff = 1'b1;
            end
        end
    end

    assign differs = present && ((r_rem_size != size_cl) || byte_diff);

    always_comb begin
        unique case (r_phase)
            PH_IDLE:  n_phase = present ? PH_FIRST : PH_IDLE;
            PH_FIRST: n_phase = present ? PH_FIRST : PH_REP1;
            PH_REP1:  n_phase = present ? PH_REP2  : PH_IDLE;
            PH_REP2:  n_phase = present ? PH_FIRST : PH_REP1;
            default:  n_phase = PH_IDLE;
        endcase
    end

    assign report       = differs || (n_phase == PH_FIRST);
    assign o_push       = accept && !i_kind && report;
    assign o_push_size  = size_cl;
    assign o_push_bytes = i_uid_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_rem_size <= '0;
        end else if (accept) begin
            if (i_kind) begin
                r_rem_size <= '0;
            end else begin
                r_phase <= n_phase;
                if (report) begin
                    r_rem_size <= size_cl;
                end
            end
        end
    end

    // bytes only matter once a report has set a nonzero size
    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_rem_uid <= i_uid_bytes;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rudd_back.sv =====
// back end: turns one queued uid report into a line of ascii characters
// depends on rudd_pkg; reads the head of rudd_queue
`default_nettype none

module rudd_back
    import rudd_pkg::*;
#(
    parameter int UID_BYTES = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_q_flags               i_q_flags,
    input  wire logic [SIZE_W-1:0]      i_size,
    input  wire logic [UID_BYTES*8-1:0] i_bytes,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [CHAR_W-1:0]           o_char,
    output logic                        o_last
);

    localparam int IDX_W = (UID_BYTES > 1) ? $clog2(UID_BYTES) : 1;

    t_ser              r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    logic              step;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic [7:0]        cur_byte;
    logic              last_byte;

    assign step      = !i_q_flags.empty && (!r_valid || i_ready);
    assign cur_byte  = i_bytes[r_idx*8 +: 8];
    assign last_byte = ((SIZE_W'(r_idx) + SIZE_W'(1)) == i_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_I;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        ch      = CH_I;
        last    = 1'b0;
        o_pop   = 1'b0;
        unique case (r_state)
            S_I: begin
                ch = CH_I;
                if (step) n_state = S_SZ_HI;
            end
            S_SZ_HI: begin
                ch = hex_digit(4'(i_size >> 4));
                if (step) n_state = S_SZ_LO;
            end
            S_SZ_LO: begin
                ch = hex_digit(i_size[3:0]);
                if (step) n_state = S_SPACE;
            end
            S_SPACE: begin
                ch = CH_SPACE;
                if (step) begin
                    n_idx   = '0;
                    n_state = (i_size == '0) ? S_CR : S_HI;
                end
            end
            S_HI: begin
                ch = hex_digit(cur_byte[7:4]);
                if (step) n_state = S_LO;
            end
            S_LO: begin
                ch = hex_digit(cur_byte[3:0]);
                if (step) begin
                    if (last_byte) begin
                        n_state = S_CR;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_HI;
                    end
                end
            end
            S_CR: begin
                ch = CH_CR;
                if (step) n_state = S_LF;
            end
            S_LF: begin
                ch    = CH_LF;
                last  = 1'b1;
                o_pop = step;
                if (step) n_state = S_I;
            end
            default: n_state = S_I;
        endcase
    end

    // output register parts the serialiser from the downstream stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_char <= ch;
            r_last <= last;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

`default_nettype wire

// ===== rtl/rfid_uid_report_dedup_unit.sv =====
// top level of the card-reader uid report unit with repeat suppression
// depends on rudd_pkg, rudd_front, rudd_queue, rudd_back and the assertion header
`default_nettype none

// Each request on the slave side is one card-reader poll result or, with
// tuser set, a reader reset that forgets the remembered uid size. A poll
// counts as a card only when both present and read-ok are set; a four-phase
// presence machine hides the reader's alternating present/absent pattern.
// When the uid differs from the last one reported, or the machine goes to or
// stays in first seen, one report line goes out on the master side, one
// character a request: 'I', the size as two hex digits, a space, two
// lowercase hex digits per uid byte, CR, then LF with tlast. The size is
// clamped to UID_BYTES. The front end takes a poll whenever the two-entry
// report queue has room; a line is 6 + 2*size characters (6 to 26), one
// character per cycle while the master side is ready, so sustained
// throughput is set by the serialiser when every poll reports and by the
// upstream poll rate otherwise. No clearing pass is needed after reset.

module rfid_uid_report_dedup_unit
    import rudd_pkg::*;
#(
    parameter int UID_BYTES = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // card_present [0], read_ok [1], uid_size [5:2], uid_low_bytes [69:6],
    // uid_high_bytes [85:70], zero pad [87:86]
    input  wire logic [IN_TDATA_W-1:0] i_s_tdata,
    // kind [0]: 0 poll result, 1 reader reset
    input  wire logic [IN_TUSER_W-1:0] i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // report_char [7:0]
    output logic [CHAR_W-1:0]          o_m_tdata,
    // last_char: set on the closing LF
    output logic                       o_m_tlast
);

    `include "rfid_uid_report_dedup_unit_assert.svh"

    localparam int UID_W = UID_BYTES * 8;
    localparam int REC_W = SIZE_W + UID_W;

    // all ten uid bytes as received, byte 0 lowest
    logic [79:0]       uid_all;
    logic [UID_W-1:0]  uid_bytes;

    logic              push;
    logic [SIZE_W-1:0] push_size;
    logic [UID_W-1:0]  push_bytes;
    logic              pop;
    logic [REC_W-1:0]  head;
    t_q_flags          q_flags;

    assign uid_all   = {i_s_tdata[85:70], i_s_tdata[69:6]};
    assign uid_bytes = uid_all[UID_W-1:0];

    // front end: classifies each poll and decides whether a line is due
    rudd_front #(
        .UID_BYTES (UID_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_kind         (i_s_tuser[0]),
        .i_card_present (i_s_tdata[0]),
        .i_read_ok      (i_s_tdata[1]),
        .i_uid_size     (i_s_tdata[5:2]),
        .i_uid_bytes    (uid_bytes),
        .i_q_flags      (q_flags),
        .o_push         (push),
        .o_push_size    (push_size),
        .o_push_bytes   (push_bytes)
    );

    // pending report lines, size above the uid bytes
    rudd_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_size, push_bytes}),
        .i_pop   (pop),
        .o_head  (head),
        .o_flags (q_flags)
    );

    // back end: one character per cycle into the output register while the master side is ready
    rudd_back #(
        .UID_BYTES (UID_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_flags (q_flags),
        .i_size    (head[REC_W-1 -: SIZE_W]),
        .i_bytes   (head[UID_W-1:0]),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_char    (o_m_tdata),
        .o_last    (o_m_tlast)
    );

    // a line always closes on LF
    `RUDD_ASSERT_IMPLIES(a_last_is_lf, o_m_tvalid && o_m_tlast, o_m_tdata == CH_LF, "tlast without LF")
    // a reader reset never produces a line
    `RUDD_ASSERT_IMPLIES(a_reset_quiet, i_s_tvalid && o_s_tready && i_s_tuser[0], !push, "reset pushed a report")
    // the front end never overruns the queue
    `RUDD_ASSERT_NEVER(a_no_overflow, push && q_flags.full, "report queue overflow")

endmodule

`default_nettype wire

// ===== test/rfid_uid_report_dedup_unit_test.sv =====
// self-checking bench for the uid report dedup unit: drives poll and reset requests,
// predicts every report character and checks the master side against it
// depends on rudd_pkg and rfid_uid_report_dedup_unit

module rfid_uid_report_dedup_unit_test;
    import rudd_pkg::*;

    localparam int UID_BYTES = 10;
    localparam int UID_W     = 8 * UID_BYTES;

    // tuser kind codes
    localparam logic KIND_POLL  = 1'b0;
    localparam logic KIND_RESET = 1'b1;

    // one slave-side request as the bench sees it
    typedef struct packed {
        logic             kind;
        logic             present;
        logic             read_ok;
        logic [3:0]       size;
        logic [UID_W-1:0] uid;
    } t_poll;

    // one master-side request
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_report_char;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // card_present [0], read_ok [1], uid_size [5:2], uid_low_bytes [69:6],
    // uid_high_bytes [85:70], zero pad [87:86]
    logic [IN_TDATA_W-1:0] i_s_tdata  = '0;
    // kind [0]
    logic [IN_TUSER_W-1:0] i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // report_char [7:0]
    logic [CHAR_W-1:0]     o_m_tdata;
    logic                  o_m_tlast;

    // bench copy of the block state
    t_phase           presence_phase;
    logic [3:0]       remembered_size;
    logic [UID_W-1:0] remembered_uid;

    t_report_char expected_report_chars[$];
    int           error_count = 0;
    int           polls_sent  = 0;
    logic         idle_on     = 1'b1;

    // small pool of cards so that the same uid comes back now and then
    logic [UID_W-1:0] card_uid[4];
    logic [3:0]       card_size[4];

    rfid_uid_report_dedup_unit #(
        .UID_BYTES(UID_BYTES)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [CHAR_W-1:0] nibble_char(input logic [3:0] v);
        return (v < 4'd10) ? CH_ZERO + CHAR_W'(v) : CH_A + CHAR_W'(v - 4'd10);
    endfunction

    function automatic void push_char(input logic [CHAR_W-1:0] c, input logic last);
        t_report_char rc;
        rc.ch   = c;
        rc.last = last;
        expected_report_chars.push_back(rc);
    endfunction

    // updates the state for one accepted request and queues the line it causes
    function automatic void predict_report_line(input t_poll p);
        logic [3:0] sz;
        logic       seen;
        logic       differs;
        int         i;
        if (p.kind == KIND_RESET) begin
            // reader reset only forgets the size
            remembered_size = '0;
        end else begin
            sz      = (p.size > UID_BYTES) ? 4'(UID_BYTES) : p.size;
            seen    = p.present & p.read_ok;
            differs = 1'b0;
            if (seen) begin
                if (remembered_size != sz) begin
                    differs = 1'b1;
                end else begin
                    for (i = 0; i < UID_BYTES; i++) begin
                        if (i < sz && remembered_uid[8*i +: 8] != p.uid[8*i +: 8]) begin
                            differs = 1'b1;
                        end
                    end
                end
            end
            case (presence_phase)
                PH_IDLE:  presence_phase = seen ? PH_FIRST : PH_IDLE;
                PH_FIRST: presence_phase = seen ? PH_FIRST : PH_REP1;
                PH_REP1:  presence_phase = seen ? PH_REP2  : PH_IDLE;
                default:  presence_phase = seen ? PH_FIRST : PH_REP1;
            endcase
            if (differs || presence_phase == PH_FIRST) begin
                push_char(CH_I, 1'b0);
                push_char(nibble_char(4'h0), 1'b0);
                push_char(nibble_char(sz), 1'b0);
                push_char(CH_SPACE, 1'b0);
                for (i = 0; i < UID_BYTES; i++) begin
                    if (i < sz) begin
                        push_char(nibble_char(p.uid[8*i+4 +: 4]), 1'b0);
                        push_char(nibble_char(p.uid[8*i +: 4]), 1'b0);
                    end
                end
                push_char(CH_CR, 1'b0);
                push_char(CH_LF, 1'b1);
                // every byte is kept, valid or not
                remembered_size = sz;
                remembered_uid  = p.uid;
            end
        end
    endfunction

    // ---------------------------------------------------------------- helpers

    function automatic t_poll make_poll(input logic kind, input logic present,
                                        input logic read_ok, input logic [3:0] size,
                                        input logic [UID_W-1:0] uid);
        t_poll p;
        p.kind    = kind;
        p.present = present;
        p.read_ok = read_ok;
        p.size    = size;
        p.uid     = uid;
        return p;
    endfunction

    function automatic logic [UID_W-1:0] random_uid();
        return {16'($urandom()), $urandom(), $urandom()};
    endfunction

    // mostly the real card sizes, now and then anything the field holds
    function automatic logic [3:0] random_size();
        int r;
        r = $urandom_range(99);
        if (r < 30) begin
            return 4'd4;
        end else if (r < 55) begin
            return 4'd7;
        end else if (r < 80) begin
            return 4'd10;
        end
        return 4'($urandom_range(15));
    endfunction

    // one request on the slave side; prediction happens at the accepting edge
    task automatic send_poll(input t_poll p);
        while (idle_on && $urandom_range(99) < 38) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {2'b00, p.uid, p.size, p.read_ok, p.present};
        i_s_tuser  = p.kind;
        do @(posedge i_clk); while (!o_s_tready);
        predict_report_line(p);
        polls_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (expected_report_chars.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------- receiver

    always @(negedge i_clk) begin
        i_m_tready <= !(idle_on && $urandom_range(99) < 38);
    end

    always @(posedge i_clk) begin
        t_report_char want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_report_chars.size() == 0) begin
                $display("%0t: unexpected report char, expected none, actual %h last %b",
                         $time, o_m_tdata, o_m_tlast);
                error_count++;
            end else begin
                want = expected_report_chars.pop_front();
                if (want.ch !== o_m_tdata || want.last !== o_m_tlast) begin
                    $display("%0t: report mismatch, expected %h last %b, actual %h last %b",
                             $time, want.ch, want.last, o_m_tdata, o_m_tlast);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // empty uid, staying in first seen, and the hidden present/absent flicker
    task automatic test_presence_machine();
        logic [UID_W-1:0] u;
        u = 80'h0123_4567_89ab_cdef_fedc;
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b1, 4'd0, '0));
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b1, 4'd0, '0));
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b1, 4'd4, u));
        send_poll(make_poll(KIND_POLL, 1'b0, 1'b1, 4'd4, u));
        // back in range while repeat 1: repeat 2, same uid so silent
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b1, 4'd4, u));
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b1, 4'd4, u));
        send_poll(make_poll(KIND_POLL, 1'b0, 1'b1, 4'd4, u));
        send_poll(make_poll(KIND_POLL, 1'b0, 1'b0, 4'd4, u));
    endtask

    // a failed read counts as absent even with a card reported
    task automatic test_failed_read();
        logic [UID_W-1:0] u;
        u = random_uid();
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b0, 4'd7, u));
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b1, 4'd7, u));
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b0, 4'd7, u));
        // repeat 2 with a different uid reports because of the change
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b1, 4'd7, ~u));
    endtask

    // sizes above the limit are clamped; all-ones and all-zeros uids
    task automatic test_size_clamp();
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b1, 4'd15, '1));
        send_poll(make_poll(KIND_POLL, 1'b0, 1'b1, 4'd15, '1));
        // clamped to the same size and uid as before: silent in repeat 2
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b1, 4'd11, '1));
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b1, 4'd10, '0));
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b1, 4'd10, 80'h0a09_0807_0605_0403_0201));
    endtask

    // reader reset forgets the size only; its other fields are ignored
    task automatic test_reader_reset();
        logic [UID_W-1:0] u;
        u = 80'hfedc_ba98_7654_3210_a5c3;
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b1, 4'd4, u));
        send_poll(make_poll(KIND_POLL, 1'b0, 1'b0, 4'd4, u));
        send_poll(make_poll(KIND_RESET, 1'b1, 1'b1, 4'd15, '1));
        // repeat 2 with an unchanged uid now reports, the size was forgotten
        send_poll(make_poll(KIND_POLL, 1'b1, 1'b1, 4'd4, u));
        send_poll(make_poll(KIND_RESET, 1'b0, 1'b0, 4'd0, '0));
        send_poll(make_poll(KIND_POLL, 1'b0, 1'b0, 4'd0, '0));
    endtask

    // a card held in range: mostly alternating present/absent with the odd glitch
    task automatic run_card_session();
        t_poll            p;
        int               slot;
        int               len;
        int               k;
        logic             on;
        logic [UID_W-1:0] keep;
        slot = $urandom_range(3);
        if ($urandom_range(99) < 35) begin
            card_uid[slot]  = random_uid();
            card_size[slot] = random_size();
        end
        len = $urandom_range(2, 10);
        on  = 1'b1;
        for (k = 0; k < len; k++) begin
            p = make_poll(KIND_POLL, on, 1'b1, card_size[slot], card_uid[slot]);
            // bytes past the valid size do not take part in the compare
            if ($urandom_range(99) < 25 && card_size[slot] < UID_BYTES) begin
                keep  = (UID_W'(1) << (8 * card_size[slot])) - 1;
                p.uid = (p.uid & keep) | (random_uid() & ~keep);
            end
            if (!on) begin
                p.read_ok = 1'($urandom_range(1));
            end else if ($urandom_range(99) < 10) begin
                p.read_ok = 1'b0;
            end
            send_poll(p);
            on = !on;
            if ($urandom_range(99) < 15) begin
                on = !on;
            end
        end
    endtask

    task automatic test_random_traffic(input int count);
        int target;
        int r;
        target = polls_sent + count;
        while (polls_sent < target) begin
            r = $urandom_range(99);
            if (r < 70) begin
                run_card_session();
            end else if (r < 82) begin
                send_poll(make_poll(1'($urandom_range(1)), 1'($urandom_range(1)),
                                    1'($urandom_range(1)), 4'($urandom_range(15)),
                                    random_uid()));
            end else if (r < 90) begin
                send_poll(make_poll(KIND_RESET, 1'($urandom_range(1)), 1'($urandom_range(1)),
                                    4'($urandom_range(15)), random_uid()));
            end else begin
                send_poll(make_poll(KIND_POLL, 1'b0, 1'($urandom_range(1)),
                                    random_size(), random_uid()));
            end
        end
    endtask

    // let every line drain before carrying on
    task automatic test_drain_pause();
        test_random_traffic(8);
        wait_drained();
        test_random_traffic(8);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        int i;
        presence_phase  = PH_IDLE;
        remembered_size = '0;
        remembered_uid  = '0;
        for (i = 0; i < 4; i++) begin
            card_uid[i]  = random_uid();
            card_size[i] = random_size();
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_presence_machine();
        test_failed_read();
        test_size_clamp();
        test_reader_reset();
        test_random_traffic(60);
        // long stretch with both sides always ready
        idle_on = 1'b0;
        test_random_traffic(50);
        idle_on = 1'b1;
        test_drain_pause();
        test_random_traffic(60);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && expected_report_chars.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
